@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the escaper checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define XTE_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define XTE_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/xte_pkg.sv @@
// ----------------------------------------------------------------------------
// xte_pkg
// Types, character constants and escape tables for the XML text escaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xte_pkg;

  localparam int unsigned MAX_RESULTS = 12;
  localparam int unsigned ESC_MAX     = 6;

  localparam logic [7:0] CH_AMP  = 8'h26;  // &
  localparam logic [7:0] CH_LT   = 8'h3C;  // <
  localparam logic [7:0] CH_GT   = 8'h3E;  // >
  localparam logic [7:0] CH_QUOT = 8'h22;  // "
  localparam logic [7:0] CH_APOS = 8'h27;  // '
  localparam logic [7:0] CH_HASH = 8'h23;  // #
  localparam logic [7:0] CH_X    = 8'h78;  // x
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ;
  localparam logic [7:0] CTRL_LIMIT = 8'd32;

  // Text arrays: element 0 is the first byte sent.
  typedef logic [ESC_MAX-1:0][7:0] xte_text_t;

  localparam xte_text_t TXT_AMP  = {8'h00, ";", "p", "m", "a", "&"};
  localparam xte_text_t TXT_LT   = {8'h00, 8'h00, ";", "t", "l", "&"};
  localparam xte_text_t TXT_GT   = {8'h00, 8'h00, ";", "t", "g", "&"};
  localparam xte_text_t TXT_QUOT = {";", "t", "o", "u", "q", "&"};
  localparam xte_text_t TXT_APOS = {";", "s", "o", "p", "a", "&"};
  localparam xte_text_t TXT_AMPH = {"#", ";", "p", "m", "a", "&"};
  localparam xte_text_t TXT_HX   = {8'h00, 8'h00, 8'h00, "x", "#", "&"};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } xte_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } xte_out_t;

  // Expanded output bytes of one request.
  typedef struct packed {
    logic [3:0]                   cnt;
    logic [MAX_RESULTS-1:0][7:0]  bytes;
  } xte_seq_t;

  typedef struct packed {
    logic [2:0] len;
    xte_text_t  text;
  } xte_esc_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_AMP  = 4'b0010,
    ST_HASH = 4'b0100,
    ST_RAW  = 4'b1000
  } xte_state_t;

  function automatic logic [7:0] xte_hex(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'h0, n};
    return 8'h37 + {4'h0, n};
  endfunction

  function automatic xte_esc_t xte_escape(input logic [7:0] b);
    xte_esc_t e;
    priority if (b == CH_AMP) begin
      e.len = 3'd5; e.text = TXT_AMP;
    end else if (b == CH_LT) begin
      e.len = 3'd4; e.text = TXT_LT;
    end else if (b == CH_GT) begin
      e.len = 3'd4; e.text = TXT_GT;
    end else if (b == CH_QUOT) begin
      e.len = 3'd6; e.text = TXT_QUOT;
    end else if (b == CH_APOS) begin
      e.len = 3'd6; e.text = TXT_APOS;
    end else if (b < CTRL_LIMIT) begin
      e.len = 3'd6;
      e.text = {CH_SEMI, xte_hex(b[3:0]), xte_hex(b[7:4]), CH_X, CH_HASH, CH_AMP};
    end else begin
      // everything else passes through
      e.len     = 3'd1;
      e.text    = '0;
      e.text[0] = b;
    end
    return e;
  endfunction

endpackage

@@ sv/xte_encoder.sv @@
// ----------------------------------------------------------------------------
// xte_encoder
// Lookahead/raw-run state and expansion of one request into output bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xte_encoder
  import xte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  xte_in_t  req,
  output xte_seq_t seq
);

  xte_state_t state_r, state_nxt;
  logic [2:0] pre_len;
  xte_text_t  pre_text;
  logic [2:0] tail_len;
  xte_text_t  tail_text;
  xte_esc_t   esc;
  logic       hold_amp;
  logic [3:0] pos;
  logic [3:0] k;

  assign esc      = xte_escape(req.in_byte);
  assign hold_amp = (req.in_byte == CH_AMP) && !req.in_last;

  always_comb begin
    state_nxt = ST_IDLE;
    pre_len   = 3'd0;
    pre_text  = TXT_AMPH;
    tail_text = esc.text;
    // plain handling of the byte by default; a lone '&' is held
    tail_len  = hold_amp ? 3'd0 : esc.len;
    if (hold_amp) state_nxt = ST_AMP;

    unique case (state_r)
      ST_RAW: begin
        state_nxt = ST_IDLE;
        if (!req.in_last) begin
          tail_len     = 3'd1;
          tail_text    = '0;
          tail_text[0] = req.in_byte;
          if (req.in_byte != CH_SEMI) state_nxt = ST_RAW;
        end else begin
          tail_len = esc.len;
        end
      end
      ST_AMP: begin
        if (req.in_byte == CH_HASH && !req.in_last) begin
          state_nxt = ST_HASH;
          tail_len  = 3'd0;
        end else begin
          pre_len = 3'd5;
        end
      end
      ST_HASH: begin
        if (req.in_byte == CH_X) begin
          pre_len   = 3'd3;
          pre_text  = TXT_HX;
          tail_len  = 3'd0;
          state_nxt = req.in_last ? ST_IDLE : ST_RAW;
        end else begin
          pre_len = 3'd6;
        end
      end
      default: begin
      end
    endcase

    if (req.in_last) state_nxt = ST_IDLE;
  end

  // Splice prefix and escaped tail into one byte sequence.
  always_comb begin
    seq.cnt   = {1'b0, pre_len} + {1'b0, tail_len};
    seq.bytes = '0;
    pos       = 4'd0;
    k         = 4'd0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      pos = 4'(i);
      k   = pos - {1'b0, pre_len};
      if (pos < {1'b0, pre_len}) begin
        seq.bytes[i] = pre_text[pos[2:0]];
      end else if (k < 4'(ESC_MAX)) begin
        seq.bytes[i] = tail_text[k[2:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/xml_text_escaper.sv @@
// An accepted request is held in the sequence buffer; its bytes then move
// one per cycle into the output register while the output is not stalled. The
// next request enters as the last byte loads; plain bytes stream at 1/cycle.
// A held '&' or '&#' produces no bytes.
// Reset (synchronous, rst_n low) empties the sequence buffer and output
// register and clears the lookahead/raw-run state.
// ----------------------------------------------------------------------------
// xml_text_escaper
// Streams a byte string through XML entity escaping with backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xml_text_escaper
  import xte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  xte_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output xte_out_t out_data
);

  xte_seq_t enc_seq;
  xte_seq_t seq_r;
  logic     seq_valid_r;
  logic     last_r;
  logic [3:0] idx_r;
  logic     out_valid_r;
  xte_out_t out_data_r;
  logic     accept;
  logic     out_load;
  logic     seq_final;

  xte_encoder u_enc (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .req    (in_data),
    .seq    (enc_seq)
  );

  assign out_load  = seq_valid_r && (!out_valid_r || out_ready);
  assign seq_final = (idx_r == seq_r.cnt - 4'd1);
  assign in_ready  = !seq_valid_r || (out_load && seq_final);
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      idx_r       <= 4'd0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        seq_valid_r <= (enc_seq.cnt != 4'd0);
        idx_r       <= 4'd0;
      end else if (out_load) begin
        seq_valid_r <= !seq_final;
        idx_r       <= idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      seq_r  <= enc_seq;
      last_r <= in_data.in_last;
    end
    if (out_load) begin
      out_data_r.out_byte   <= seq_r.bytes[idx_r];
      out_data_r.run_last   <= seq_final;
      out_data_r.string_end <= seq_final && last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ sv/xte_checker.sv @@
// ----------------------------------------------------------------------------
// xte_checker
// Port-level assertions for the XML text escaper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module xte_checker
  import xte_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input xte_out_t out_data
);

  // stalled output holds
  `XTE_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "output changed while stalled")

  // string end only on the last byte of a request
  `XTE_ASSERT(a_end_is_run_last, clk, rst_n, out_valid && out_data.string_end |-> out_data.run_last, "string_end without run_last")

  `XTE_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "output valid after reset")

endmodule

bind xml_text_escaper xte_checker u_xte_checker (.*);

@@ tb/sv/xte_escape_checker.sv @@
// ----------------------------------------------------------------------------
// xte_escape_checker
// Watches both channels of the XML text escaper. It predicts the escaped
// bytes of every accepted request and compares each accepted result with the
// oldest predicted byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xte_escape_checker
  import xte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  xte_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  xte_out_t out_data,
  output int       fail_count,
  output int       bytes_owed
);

  localparam int REPORT_LIMIT = 10;

  // Held lookahead: 0 nothing, 1 "&", 2 "&#".
  logic [1:0] held_n;
  logic       raw_run;
  logic [7:0] text_buf[$];
  xte_out_t   escaped_q[$];
  string      digits = "0123456789ABCDEF";

  function automatic void emit_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void emit_escaped(input logic [7:0] b);
    case (b)
      CH_AMP:  emit_str("&amp;");
      CH_LT:   emit_str("&lt;");
      CH_GT:   emit_str("&gt;");
      CH_QUOT: emit_str("&quot;");
      CH_APOS: emit_str("&apos;");
      default: begin
        if (b < CTRL_LIMIT) begin
          emit_str("&#x");
          text_buf.push_back(digits[b[7:4]]);
          text_buf.push_back(digits[b[3:0]]);
          text_buf.push_back(CH_SEMI);
        end else begin
          text_buf.push_back(b);
        end
      end
    endcase
  endfunction

  function automatic void emit_plain(input logic [7:0] b, input logic last);
    if (b == CH_AMP && !last) held_n = 2'd1;
    else emit_escaped(b);
  endfunction

  // Expands one request and queues its result bytes.
  function automatic void predict_escape(input logic [7:0] b, input logic last);
    int n;
    text_buf.delete();
    if (raw_run) begin
      if (last) begin
        raw_run = 1'b0;
        emit_escaped(b);
      end else begin
        text_buf.push_back(b);
        if (b == CH_SEMI) raw_run = 1'b0;
      end
    end else if (held_n == 2'd1) begin
      held_n = 2'd0;
      if (b == CH_HASH && !last) begin
        held_n = 2'd2;
      end else begin
        emit_str("&amp;");
        emit_plain(b, last);
      end
    end else if (held_n == 2'd2) begin
      held_n = 2'd0;
      if (b == CH_X) begin
        emit_str("&#x");
        if (!last) raw_run = 1'b1;
      end else begin
        emit_str("&amp;#");
        emit_plain(b, last);
      end
    end else begin
      held_n = 2'd0;
      emit_plain(b, last);
    end
    if (last) begin
      held_n  = 2'd0;
      raw_run = 1'b0;
    end
    n = text_buf.size();
    for (int i = 0; i < n; i++)
      escaped_q.push_back('{out_byte: text_buf[i], run_last: (i == n - 1),
                            string_end: (last && i == n - 1)});
  endfunction

  always @(posedge clk) begin
    xte_out_t want;
    if (!rst_n) begin
      held_n  = 2'd0;
      raw_run = 1'b0;
      escaped_q.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (escaped_q.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("%0t: unexpected result byte %h run_last %b string_end %b",
                     $realtime, out_data.out_byte, out_data.run_last,
                     out_data.string_end);
          fail_count <= fail_count + 1;
        end else begin
          want = escaped_q.pop_front();
          if (want.out_byte !== out_data.out_byte ||
              want.run_last !== out_data.run_last ||
              want.string_end !== out_data.string_end) begin
            if (fail_count < REPORT_LIMIT)
              $display("%0t: mismatch byte exp %h got %h, run_last exp %b got %b, %s%b got %b",
                       $realtime, want.out_byte, out_data.out_byte, want.run_last,
                       out_data.run_last, "string_end exp ", want.string_end,
                       out_data.string_end);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) predict_escape(in_data.in_byte, in_data.in_last);
    end
    bytes_owed <= escaped_q.size();
  end

endmodule

@@ tb/sv/xml_text_escaper_test.sv @@
// ----------------------------------------------------------------------------
// xml_text_escaper_test
// Drives strings through the XML text escaper: a directed set covering every
// escape, lookahead and raw run case, then random well-formed and broken
// strings under changing idle rates and one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xml_text_escaper_test;
  import xte_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 186;
  localparam int DRAIN_WAIT   = 8;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  xte_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  xte_out_t out_data;

  int fail_count;
  int bytes_owed;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_reqs     = 0;
  int holds_served  = 0;
  int random_sent   = 0;
  int quiet_cycles  = 0;

  always #1 clk = ~clk;

  xml_text_escaper uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  xte_escape_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .bytes_owed(bytes_owed)
  );

  // Output side: random stalls, plus a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        holds_served++;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("xml_text_escaper test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Valid only drops when a gap is inserted, so it never toggles in one step.
  task automatic send_char(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_byte: b, in_last: last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bytes_owed != 0) @(posedge clk);
  endtask

  task automatic directed_strings();
    // extremes, control boundary and the named escapes
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h1F, 1'b0);
    send_char(8'h20, 1'b0);
    send_char(CH_LT, 1'b0);
    send_char(CH_GT, 1'b0);
    send_char(CH_QUOT, 1'b0);
    send_char(CH_APOS, 1'b0);
    // held bytes not followed by the expected lookahead
    send_char(CH_AMP, 1'b0);
    send_char(CH_AMP, 1'b0);
    send_char(CH_HASH, 1'b0);
    send_char(8'h79, 1'b0);
    // raw run closed by a semicolon
    send_char(CH_AMP, 1'b0);
    send_char(CH_HASH, 1'b0);
    send_char(CH_X, 1'b0);
    send_char(8'h41, 1'b0);
    send_char(CH_LT, 1'b0);
    send_char(CH_SEMI, 1'b0);
    // raw run cut by the end of string
    send_char(CH_AMP, 1'b0);
    send_char(CH_HASH, 1'b0);
    send_char(CH_X, 1'b0);
    send_char(8'h51, 1'b0);
    send_char(CH_LT, 1'b1);
    // lookahead at string end
    send_char(CH_AMP, 1'b1);
    send_char(CH_AMP, 1'b0);
    send_char(CH_HASH, 1'b0);
    send_char(CH_X, 1'b1);
    send_char(CH_AMP, 1'b0);
    send_char(CH_HASH, 1'b1);
  endtask

  task automatic random_string();
    logic [7:0] chars[$];
    logic [7:0] ch;
    int         segs;
    int         k;
    segs = $urandom_range(1, 5);
    repeat (segs) begin
      case ($urandom_range(0, 7))
        0: chars.push_back(8'($urandom_range(0, 255)));
        1: begin
          case ($urandom_range(0, 6))
            0:       ch = CH_LT;
            1:       ch = CH_GT;
            2:       ch = CH_QUOT;
            3:       ch = CH_APOS;
            4:       ch = CH_AMP;
            5:       ch = CH_HASH;
            default: ch = CH_SEMI;
          endcase
          chars.push_back(ch);
        end
        2: chars.push_back(8'($urandom_range(0, 31)));
        3: begin
          chars.push_back(CH_AMP);
          chars.push_back(8'($urandom_range(0, 255)));
        end
        4: begin
          chars.push_back(CH_AMP);
          chars.push_back(CH_HASH);
          chars.push_back(8'($urandom_range(0, 255)));
        end
        7: chars.push_back(CH_AMP);
        default: begin
          chars.push_back(CH_AMP);
          chars.push_back(CH_HASH);
          chars.push_back(CH_X);
          k = $urandom_range(0, 5);
          repeat (k) chars.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 3) != 0) chars.push_back(CH_SEMI);
        end
      endcase
    end
    foreach (chars[i]) begin
      send_char(chars[i], i == chars.size() - 1);
      random_sent++;
    end
  endtask

  task automatic random_strings(input int n);
    int stop_at;
    stop_at = random_sent + n;
    while (random_sent < stop_at) random_string();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 11;
    recv_idle_pct = 54;
    directed_strings();
    random_strings(RANDOM_ITEMS / 3);
    wait_drained();

    send_idle_pct = 54;
    recv_idle_pct = 11;
    random_strings(RANDOM_ITEMS / 3);
    wait_drained();

    // no idling; the long output hold fills the block while requests keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_reqs <= hold_reqs + 1;
    random_strings(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    wait_drained();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0 && bytes_owed == 0) begin
      $display("xml_text_escaper test passed");
    end else begin
      $display("xml_text_escaper test failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/xte_pkg.sv
sv/xte_encoder.sv
sv/xml_text_escaper.sv
sv/xte_checker.sv
tb/sv/xte_escape_checker.sv
tb/sv/xml_text_escaper_test.sv
